[design/grdc_pkg.sv]
// ----------------------------------------------------------------------------
// grdc_pkg
// Shared types and constants of the gamepad radial deadzone conditioner.
// ----------------------------------------------------------------------------
package grdc_pkg;

    localparam logic [14:0] DZ_MIN      = 15'd1638;
    localparam logic [14:0] DZ_MAX      = 15'd19660;
    localparam logic [14:0] DZ_RESET    = 15'd7849;
    localparam logic [15:0] PROBE_RESET = 16'd1000;
    localparam logic [14:0] Q_ONE       = 15'd32767;
    localparam int          ROOT_STEPS  = 16;
    localparam int          DIV_STEPS   = 31;

    typedef enum logic [1:0] {
        REG_ENABLE   = 2'd0,
        REG_DEADZONE = 2'd1,
        REG_PROBE    = 2'd2,
        REG_NONE     = 2'd3
    } t_reg_idx;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_TAKE,
        DP_OFF,
        DP_LOSE,
        DP_PROBE_FAIL,
        DP_PROBE_OK,
        DP_SQX,
        DP_SQY,
        DP_ROOT,
        DP_MAG,
        DP_DIV,
        DP_SVAL,
        DP_MUL,
        DP_OUT,
        DP_ZERO,
        DP_FIN,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic        op;
        logic [15:0] raw_left_x;
        logic [15:0] raw_left_y;
        logic [15:0] raw_right_x;
        logic [15:0] raw_right_y;
        logic [15:0] button_bits;
        logic [7:0]  left_trigger_raw;
        logic [7:0]  right_trigger_raw;
        logic        device_ok;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic        connected;
        logic [15:0] left_x;
        logic [15:0] left_y;
        logic [15:0] right_x;
        logic [15:0] right_y;
        logic [7:0]  left_trigger;
        logic [7:0]  right_trigger;
        logic [15:0] held_buttons;
        logic [15:0] pressed_buttons;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_item;

    typedef struct packed {
        t_dp_op op;
        logic   stick;
        logic   axis_y;
    } t_cmd;

    typedef struct packed {
        logic is_take;
        logic enable;
        logic following;
        logic ok;
        logic backoff;
        logic connected;
        logic mag_le_dz;
    } t_stat;

endpackage

[design/grdc_ifs.sv]
// ----------------------------------------------------------------------------
// grdc_ifs
// Valid/ready channels for sample items, result items and register writes.
// ----------------------------------------------------------------------------
interface grdc_in_if;
    import grdc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface grdc_out_if;
    import grdc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface grdc_cfg_if;
    import grdc_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/gamepad_radial_deadzone_conditioner_core.sv]
// ----------------------------------------------------------------------------
// gamepad_radial_deadzone_conditioner_core
// Pad sample conditioner: radial deadzone per stick, link tracking and
// latched button presses.
// ----------------------------------------------------------------------------
// channel | dir | payload                          | handshake
// i_in    | in  | op, raw axes, buttons, triggers  | valid / ready
// o_out   | out | connected, axes, triggers, masks | valid / ready
// i_cfg   | in  | index, data                      | valid / ready (always ready)
//
// Take items and items that publish off go through capture, decide and emit to
// the result register. A conditioned poll runs per stick 16 square root steps
// and three 31-step restoring divides on one shared bit-serial divider.
// A stick inside the deadzone skips its divides.
// One item at a time; the next is taken while the last result waits.
// Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
module gamepad_radial_deadzone_conditioner_core
    import grdc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    grdc_in_if.sink      i_in,
    grdc_out_if.source   o_out,
    grdc_cfg_if.sink     i_cfg
);

    t_cmd  cmd;
    t_stat stat;

    assign i_cfg.ready = 1'b1;

    grdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    grdc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_in.data),
        .i_cfg_we (i_cfg.valid),
        .i_cfg    (i_cfg.data),
        .o_stat   (stat),
        .o_item   (o_out.data)
    );

endmodule

[design/grdc_dp.sv]
// ----------------------------------------------------------------------------
// grdc_dp
// Datapath: registers, link state, shared square root and divider steps.
// ----------------------------------------------------------------------------
module grdc_dp
    import grdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    input  logic      i_cfg_we,
    input  t_cfg_item i_cfg,
    output t_stat     o_stat,
    output t_out_item o_item
);

    logic        r_enable;
    logic [14:0] r_dz;
    logic [15:0] r_probe;
    t_in_item    r_in;
    logic        r_following;
    logic [31:0] r_npt;
    logic [15:0] r_prev;
    logic [15:0] r_latch;
    logic [15:0] r_axes [4];
    logic [7:0]  r_trig [2];
    logic [15:0] r_held;
    logic        r_conn;
    logic [15:0] r_pressed;
    logic [31:0] r_val;
    logic [31:0] r_root;
    logic [31:0] r_bit;
    logic [15:0] r_mag;
    logic [30:0] r_num;
    logic [15:0] r_den;
    logic [15:0] r_rem;
    logic [30:0] r_quo;
    logic [14:0] r_s;
    logic        r_neg;
    t_out_item   r_out;

    logic signed [15:0] ax_x, ax_y, cur;
    logic [14:0]        cur_abs;
    logic [31:0]        sq;
    logic [31:0]        trial;
    logic [16:0]        rem_sh;
    logic [15:0]        diff;
    logic [15:0]        q;
    logic [14:0]        wdz;
    logic [1:0]         aidx;

    function automatic logic signed [15:0] clamp(input logic [15:0] a);
        clamp = (a == 16'h8000) ? 16'sh8001 : $signed(a);
    endfunction

    always_comb begin
        ax_x    = i_cmd.stick ? clamp(r_in.raw_right_x) : clamp(r_in.raw_left_x);
        ax_y    = i_cmd.stick ? clamp(r_in.raw_right_y) : clamp(r_in.raw_left_y);
        cur     = i_cmd.axis_y ? ax_y : ax_x;
        cur_abs = cur[15] ? 15'(-cur) : cur[14:0];
        sq      = $unsigned(32'(cur) * 32'(cur));
        trial   = r_root + r_bit;
        rem_sh  = {r_rem, r_num[30]};
        diff    = r_root[15:0] - {1'b0, r_dz};
        q       = r_quo[15:0];
        aidx    = {i_cmd.stick, i_cmd.axis_y};
        wdz     = i_cfg.data[14:0];
        if (wdz < DZ_MIN) begin
            wdz = DZ_MIN;
        end else if (wdz > DZ_MAX) begin
            wdz = DZ_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_dz        <= DZ_RESET;
            r_probe     <= PROBE_RESET;
            r_following <= 1'b0;
            r_npt       <= '0;
            r_prev      <= '0;
            r_latch     <= '0;
            r_axes      <= '{default: '0};
            r_trig      <= '{default: '0};
            r_held      <= '0;
            r_conn      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_ENABLE:   r_enable <= i_cfg.data[0];
                    REG_DEADZONE: r_dz     <= wdz;
                    REG_PROBE:    r_probe  <= i_cfg.data;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                DP_TAKE: begin
                    r_latch <= '0;
                end
                DP_OFF, DP_LOSE, DP_PROBE_FAIL: begin
                    r_conn <= 1'b0;
                    r_axes <= '{default: '0};
                    r_trig <= '{default: '0};
                    r_held <= '0;
                    r_prev <= '0;
                    if (i_cmd.op != DP_OFF) begin
                        r_npt <= r_in.now_ms + {16'd0, r_probe};
                    end
                    if (i_cmd.op == DP_LOSE) begin
                        r_following <= 1'b0;
                    end
                end
                DP_PROBE_OK: begin
                    r_npt       <= r_in.now_ms + {16'd0, r_probe};
                    r_following <= 1'b1;
                    r_prev      <= r_in.button_bits;
                    r_latch     <= '0;
                end
                DP_OUT: begin
                    r_axes[aidx] <= r_neg ? -q : q;
                end
                DP_ZERO: begin
                    r_axes[{i_cmd.stick, 1'b0}] <= '0;
                    r_axes[{i_cmd.stick, 1'b1}] <= '0;
                end
                DP_FIN: begin
                    r_trig[0] <= r_in.left_trigger_raw;
                    r_trig[1] <= r_in.right_trigger_raw;
                    r_latch   <= r_latch | (r_in.button_bits & ~r_prev);
                    r_prev    <= r_in.button_bits;
                    r_held    <= r_in.button_bits;
                    r_conn    <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_CAPTURE: begin
                r_in      <= i_item;
                r_pressed <= '0;
            end
            DP_TAKE: begin
                r_pressed <= r_latch;
            end
            DP_SQX: begin
                r_val <= sq;
            end
            DP_SQY: begin
                r_val  <= r_val + sq;
                r_root <= '0;
                r_bit  <= 32'h4000_0000;
            end
            DP_ROOT: begin
                if (r_val >= trial) begin
                    r_val  <= r_val - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            DP_MAG: begin
                r_mag <= r_root[15:0];
                r_num <= {diff, 15'd0} - {15'd0, diff};
                r_den <= {1'b0, Q_ONE - r_dz};
                r_rem <= '0;
            end
            DP_DIV: begin
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= 16'(rem_sh - {1'b0, r_den});
                    r_quo <= {r_quo[29:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[15:0];
                    r_quo <= {r_quo[29:0], 1'b0};
                end
                r_num <= {r_num[29:0], 1'b0};
            end
            DP_SVAL: begin
                r_s <= (r_quo > {16'd0, Q_ONE}) ? Q_ONE : r_quo[14:0];
            end
            DP_MUL: begin
                r_num <= {1'b0, 30'(cur_abs) * 30'(r_s)};
                r_den <= r_mag;
                r_rem <= '0;
                r_neg <= cur[15];
            end
            DP_EMIT: begin
                r_out.connected       <= r_conn;
                r_out.left_x          <= r_axes[0];
                r_out.left_y          <= r_axes[1];
                r_out.right_x         <= r_axes[2];
                r_out.right_y         <= r_axes[3];
                r_out.left_trigger    <= r_trig[0];
                r_out.right_trigger   <= r_trig[1];
                r_out.held_buttons    <= r_held;
                r_out.pressed_buttons <= r_pressed;
            end
            default: ;
        endcase
    end

    assign o_stat.is_take   = r_in.op;
    assign o_stat.enable    = r_enable;
    assign o_stat.following = r_following;
    assign o_stat.ok        = r_in.device_ok;
    assign o_stat.backoff   = r_in.now_ms < r_npt;
    assign o_stat.connected = r_conn;
    assign o_stat.mag_le_dz = r_root[15:0] <= {1'b0, r_dz};
    assign o_item           = r_out;

endmodule

[design/grdc_ctrl.sv]
// ----------------------------------------------------------------------------
// grdc_ctrl
// Controller: sequences one item through decision, root, divides and emit.
// ----------------------------------------------------------------------------
module grdc_ctrl
    import grdc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000_0000_0000_0001,
        S_DECIDE = 16'b0000_0000_0000_0010,
        S_SQX    = 16'b0000_0000_0000_0100,
        S_SQY    = 16'b0000_0000_0000_1000,
        S_ROOT   = 16'b0000_0000_0001_0000,
        S_MAG    = 16'b0000_0000_0010_0000,
        S_DIVS   = 16'b0000_0000_0100_0000,
        S_SVAL   = 16'b0000_0000_1000_0000,
        S_MULX   = 16'b0000_0001_0000_0000,
        S_DIVX   = 16'b0000_0010_0000_0000,
        S_OUTX   = 16'b0000_0100_0000_0000,
        S_MULY   = 16'b0000_1000_0000_0000,
        S_DIVY   = 16'b0001_0000_0000_0000,
        S_OUTY   = 16'b0010_0000_0000_0000,
        S_FIN    = 16'b0100_0000_0000_0000,
        S_EMIT   = 16'b1000_0000_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_stick, n_stick;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_stick      = r_stick;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd.op     = DP_NOP;
        o_cmd.stick  = r_stick;
        o_cmd.axis_y = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_CAPTURE;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_stick = 1'b0;
                n_state = S_EMIT;
                if (i_stat.is_take) begin
                    o_cmd.op = DP_TAKE;
                end else if (!i_stat.enable) begin
                    if (i_stat.connected) begin
                        o_cmd.op = DP_OFF;
                    end
                end else if (i_stat.following && !i_stat.ok) begin
                    o_cmd.op = DP_LOSE;
                end else if (!i_stat.following && i_stat.backoff) begin
                    o_cmd.op = DP_OFF;
                end else if (!i_stat.following && !i_stat.ok) begin
                    o_cmd.op = DP_PROBE_FAIL;
                end else begin
                    if (!i_stat.following) begin
                        o_cmd.op = DP_PROBE_OK;
                    end
                    n_state = S_SQX;
                end
            end
            S_SQX: begin
                o_cmd.op = DP_SQX;
                n_state  = S_SQY;
            end
            S_SQY: begin
                o_cmd.op     = DP_SQY;
                o_cmd.axis_y = 1'b1;
                n_cnt        = '0;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.op = DP_ROOT;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'(ROOT_STEPS - 1)) begin
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                n_cnt = '0;
                if (i_stat.mag_le_dz) begin
                    o_cmd.op = DP_ZERO;
                    n_stick  = 1'b1;
                    n_state  = r_stick ? S_FIN : S_SQX;
                end else begin
                    o_cmd.op = DP_MAG;
                    n_state  = S_DIVS;
                end
            end
            S_DIVS, S_DIVX, S_DIVY: begin
                o_cmd.op = DP_DIV;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    n_state = (r_state == S_DIVS) ? S_SVAL :
                              (r_state == S_DIVX) ? S_OUTX : S_OUTY;
                end
            end
            S_SVAL: begin
                o_cmd.op = DP_SVAL;
                n_state  = S_MULX;
            end
            S_MULX: begin
                o_cmd.op = DP_MUL;
                n_cnt    = '0;
                n_state  = S_DIVX;
            end
            S_OUTX: begin
                o_cmd.op = DP_OUT;
                n_state  = S_MULY;
            end
            S_MULY: begin
                o_cmd.op     = DP_MUL;
                o_cmd.axis_y = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIVY;
            end
            S_OUTY: begin
                o_cmd.op     = DP_OUT;
                o_cmd.axis_y = 1'b1;
                n_stick      = 1'b1;
                n_state      = r_stick ? S_FIN : S_SQX;
            end
            S_FIN: begin
                o_cmd.op = DP_FIN;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = DP_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_stick     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_stick     <= n_stick;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[design/grdc_checker.sv]
// ----------------------------------------------------------------------------
// grdc_checker
// Port-level checks of the conditioner core.
// ----------------------------------------------------------------------------
module grdc_checker
    import grdc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data,
    input logic      i_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result item dropped or changed under stall");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("reset left a pending item");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while one is in work");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.left_x != 16'h8000 && i_out_data.left_y != 16'h8000
            && i_out_data.right_x != 16'h8000 && i_out_data.right_y != 16'h8000)
        else $error("axis out of symmetric range");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("register port stalled");

endmodule

bind gamepad_radial_deadzone_conditioner_core grdc_checker u_grdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data),
    .i_cfg_ready (i_cfg.ready)
);
